[src/huffman_code_builder_defines.svh]
// assertion macros used by the huffman code builder datapath
`ifndef HUFFMAN_CODE_BUILDER_DEFINES_SVH
`define HUFFMAN_CODE_BUILDER_DEFINES_SVH

// same-cycle implication, clocked on clk_i, off while rst_ni is low
`define HCB_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("huffman code builder check failed");

// next-cycle implication, clocked on clk_i, off while rst_ni is low
`define HCB_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("huffman code builder check failed");

`endif

[src/hcb_pkg.sv]
// shared types and field widths of the huffman code builder
`timescale 1ns / 1ps
`default_nettype none
package hcb_pkg;

  localparam int unsigned InDataW  = 16;
  localparam int unsigned SymIdxW  = 4;
  localparam int unsigned LenW     = 4;
  localparam int unsigned CodeW    = 15;
  localparam int unsigned OutDataW = 24;

  // commands from the controller, each decoded from the controller state
  typedef struct packed {
    logic load;
    logic prep;
    logic scan_en;
    logic take_a;
    logic merge;
    logic par_b;
    logic walk_st;
    logic emit;
  } cmd_t;

  // status from the datapath
  typedef struct packed {
    logic acc_last;
    logic multi;
    logic scan_done;
    logic merge_last;
    logic at_root;
    logic slot_free;
    logic last_sym;
  } sts_t;

endpackage
`default_nettype wire

[src/hcb_ram.sv]
// generic single write port ram with registered read
`timescale 1ns / 1ps
`default_nettype none
module hcb_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 4
) (
  input  wire logic                       clk_i,
  input  wire logic                       we_i,
  input  wire logic [$clog2(DEPTH)-1:0]   waddr_i,
  input  wire logic [WIDTH-1:0]           wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0]   raddr_i,
  output logic      [WIDTH-1:0]           rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule
`default_nettype wire

[src/hcb_ctrl.sv]
// sequencing state machine of the huffman code builder
`timescale 1ns / 1ps
`default_nettype none
module hcb_ctrl (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire hcb_pkg::sts_t sts_i,
  output hcb_pkg::cmd_t      cmd_o
);
  import hcb_pkg::*;

  typedef enum logic [10:0] {
    S_LOAD    = 11'b000_0000_0001,
    S_PREP    = 11'b000_0000_0010,
    S_SCAN_A  = 11'b000_0000_0100,
    S_TAKE_A  = 11'b000_0000_1000,
    S_SCAN_B  = 11'b000_0001_0000,
    S_MERGE   = 11'b000_0010_0000,
    S_PAR_B   = 11'b000_0100_0000,
    S_CHK     = 11'b000_1000_0000,
    S_WALK_RD = 11'b001_0000_0000,
    S_WALK_ST = 11'b010_0000_0000,
    S_EMIT    = 11'b100_0000_0000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_LOAD:    if (sts_i.acc_last) state_d = S_PREP;
      S_PREP:    state_d = sts_i.multi ? S_SCAN_A : S_CHK;
      S_SCAN_A:  if (sts_i.scan_done) state_d = S_TAKE_A;
      S_TAKE_A:  state_d = S_SCAN_B;
      S_SCAN_B:  if (sts_i.scan_done) state_d = S_MERGE;
      S_MERGE:   state_d = S_PAR_B;
      S_PAR_B:   state_d = sts_i.merge_last ? S_CHK : S_SCAN_A;
      S_CHK:     state_d = (sts_i.multi && !sts_i.at_root) ? S_WALK_RD : S_EMIT;
      S_WALK_RD: state_d = S_WALK_ST;
      S_WALK_ST: state_d = S_CHK;
      S_EMIT: begin
        if (sts_i.slot_free) begin
          state_d = sts_i.last_sym ? S_LOAD : S_CHK;
        end
      end
      default:   state_d = S_LOAD;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_LOAD;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    cmd_o         = '0;
    cmd_o.load    = (state_q == S_LOAD);
    cmd_o.prep    = (state_q == S_PREP);
    cmd_o.scan_en = (state_q == S_SCAN_A) || (state_q == S_SCAN_B);
    cmd_o.take_a  = (state_q == S_TAKE_A);
    cmd_o.merge   = (state_q == S_MERGE);
    cmd_o.par_b   = (state_q == S_PAR_B);
    cmd_o.walk_st = (state_q == S_WALK_ST);
    cmd_o.emit    = (state_q == S_EMIT);
  end

endmodule
`default_nettype wire

[src/hcb_datapath.sv]
// node store, least-pair scan, tree merge and code walk datapath
`timescale 1ns / 1ps
`default_nettype none
`include "huffman_code_builder_defines.svh"
module hcb_datapath #(
  parameter int unsigned MAX_SYMBOLS = 16,
  parameter int unsigned FREQ_WIDTH  = 16
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire hcb_pkg::cmd_t                    cmd_i,
  output hcb_pkg::sts_t                         sts_o,
  input  wire logic                             s_axis_tvalid,
  output logic                                  s_axis_tready,
  input  wire logic [hcb_pkg::InDataW-1:0]      s_axis_tdata,
  input  wire logic                             s_axis_tlast,
  output logic                                  m_axis_tvalid,
  input  wire logic                             m_axis_tready,
  output logic      [hcb_pkg::OutDataW-1:0]     m_axis_tdata,
  output logic                                  m_axis_tlast,
  output logic                                  m_axis_tuser
);
  import hcb_pkg::*;

  localparam int unsigned NodeCount = 2 * MAX_SYMBOLS - 1;
  localparam int unsigned NodeW     = $clog2(NodeCount);
  localparam int unsigned NW1       = $clog2(NodeCount + 1);
  localparam int unsigned CntW      = $clog2(MAX_SYMBOLS + 1);
  localparam int unsigned TieW      = $clog2(MAX_SYMBOLS);
  localparam int unsigned WeightW   = FREQ_WIDTH + TieW;
  localparam logic [InDataW-1:0] FreqMask = (FREQ_WIDTH >= InDataW) ? '1 :
      InDataW'((64'd1 << FREQ_WIDTH) - 64'd1);

  // per-run counters
  logic [NodeCount-1:0] live_q;
  logic [CntW-1:0]      count_q, live_cnt_q;
  logic                 dropped_q;
  logic [NW1-1:0]       n_q;

  // scan pipeline and running minimum
  logic [NW1-1:0]       scan_i_q;
  logic                 p_v_q;
  logic [NodeW-1:0]     p_idx_q;
  logic                 best_found_q;
  logic [WeightW-1:0]   best_w_q, a_w_q;
  logic [TieW-1:0]      best_t_q, a_t_q;
  logic [NodeW-1:0]     best_idx_q, a_idx_q;

  // code walk
  logic [TieW-1:0]      s_q;
  logic [NodeW-1:0]     cur_q;
  logic [NW1-1:0]       depth_q;
  logic [CodeW-1:0]     bits_q;

  // output register
  logic                 out_valid_q, out_ovf_q, out_last_q;
  logic [SymIdxW-1:0]   out_sym_q;
  logic [LenW-1:0]      out_len_q;
  logic [CodeW-1:0]     out_bits_q;

  logic [WeightW+TieW-1:0] wram_rdata, wram_wdata;
  logic [NodeW-1:0]        wram_waddr, pram_waddr;
  logic                    wram_we, pram_we;
  logic [NodeW:0]          pram_rdata, pram_wdata;
  logic [WeightW-1:0]      rd_w, freq_w;
  logic [TieW-1:0]         rd_t;
  logic [NodeW-1:0]        ld_idx, n_idx;
  logic accept, store, issue, better, scan_rst, walk_init, emit_go, finish, next_sym;

  assign accept   = cmd_i.load && s_axis_tvalid;
  assign store    = accept && (count_q < CntW'(MAX_SYMBOLS));
  assign freq_w   = WeightW'(s_axis_tdata & FreqMask);
  assign ld_idx   = NodeW'(count_q);
  assign n_idx    = n_q[NodeW-1:0];
  assign rd_w     = wram_rdata[WeightW+TieW-1:TieW];
  assign rd_t     = wram_rdata[TieW-1:0];

  assign wram_we    = store || cmd_i.merge;
  assign wram_waddr = cmd_i.merge ? n_idx : ld_idx;
  assign wram_wdata = cmd_i.merge ? {a_w_q + best_w_q, a_t_q}
                                  : {freq_w, count_q[TieW-1:0]};

  assign pram_we    = cmd_i.merge || cmd_i.par_b;
  assign pram_waddr = cmd_i.merge ? a_idx_q : best_idx_q;
  assign pram_wdata = {n_idx, cmd_i.par_b};

  hcb_ram #(.WIDTH(WeightW + TieW), .DEPTH(NodeCount)) u_weight_ram (
    .clk_i   (clk_i),
    .we_i    (wram_we),
    .waddr_i (wram_waddr),
    .wdata_i (wram_wdata),
    .raddr_i (scan_i_q[NodeW-1:0]),
    .rdata_o (wram_rdata)
  );

  hcb_ram #(.WIDTH(NodeW + 1), .DEPTH(NodeCount)) u_parent_ram (
    .clk_i   (clk_i),
    .we_i    (pram_we),
    .waddr_i (pram_waddr),
    .wdata_i (pram_wdata),
    .raddr_i (cur_q),
    .rdata_o (pram_rdata)
  );

  assign issue  = cmd_i.scan_en && (scan_i_q < n_q);
  assign better = live_q[p_idx_q] &&
                  (!best_found_q || (rd_w < best_w_q) ||
                   ((rd_w == best_w_q) && (rd_t < best_t_q)));
  assign scan_rst = cmd_i.prep || cmd_i.take_a || cmd_i.par_b;

  always_comb begin
    sts_o            = '0;
    sts_o.acc_last   = accept && s_axis_tlast;
    sts_o.multi      = count_q > CntW'(1);
    sts_o.scan_done  = p_v_q && (NW1'(p_idx_q) == n_q - NW1'(1));
    sts_o.merge_last = live_cnt_q == CntW'(2);
    sts_o.at_root    = NW1'(cur_q) == n_q - NW1'(1);
    sts_o.slot_free  = !out_valid_q || m_axis_tready;
    sts_o.last_sym   = (CntW'(s_q) + CntW'(1)) == count_q;
  end

  assign walk_init = cmd_i.prep || (cmd_i.par_b && sts_o.merge_last);
  assign emit_go   = cmd_i.emit && sts_o.slot_free;
  assign finish    = emit_go && sts_o.last_sym;
  assign next_sym  = emit_go && !sts_o.last_sym;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      live_q       <= '0;
      count_q      <= '0;
      live_cnt_q   <= '0;
      dropped_q    <= 1'b0;
      n_q          <= '0;
      scan_i_q     <= '0;
      p_v_q        <= 1'b0;
      best_found_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      if (store) begin
        live_q[ld_idx] <= 1'b1;
        count_q        <= count_q + CntW'(1);
      end
      if (accept && !store) begin
        dropped_q <= 1'b1;
      end
      if (cmd_i.prep) begin
        n_q        <= NW1'(count_q);
        live_cnt_q <= count_q;
      end
      if (cmd_i.take_a) begin
        live_q[best_idx_q] <= 1'b0;
      end
      if (cmd_i.merge) begin
        live_q[best_idx_q] <= 1'b0;
        live_q[n_idx]      <= 1'b1;
      end
      if (cmd_i.par_b) begin
        n_q        <= n_q + NW1'(1);
        live_cnt_q <= live_cnt_q - CntW'(1);
      end
      if (scan_rst) begin
        scan_i_q     <= '0;
        p_v_q        <= 1'b0;
        best_found_q <= 1'b0;
      end else if (cmd_i.scan_en) begin
        p_v_q <= issue;
        if (issue) begin
          scan_i_q <= scan_i_q + NW1'(1);
        end
        if (p_v_q && better) begin
          best_found_q <= 1'b1;
        end
      end
      if (emit_go) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
      if (finish) begin
        live_q    <= '0;
        count_q   <= '0;
        dropped_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.scan_en) begin
      p_idx_q <= scan_i_q[NodeW-1:0];
      if (p_v_q && better) begin
        best_w_q   <= rd_w;
        best_t_q   <= rd_t;
        best_idx_q <= p_idx_q;
      end
    end
    if (cmd_i.take_a) begin
      a_w_q   <= best_w_q;
      a_t_q   <= best_t_q;
      a_idx_q <= best_idx_q;
    end
    if (walk_init) begin
      s_q     <= '0;
      cur_q   <= '0;
      depth_q <= '0;
      bits_q  <= '0;
    end else if (next_sym) begin
      s_q     <= s_q + TieW'(1);
      cur_q   <= NodeW'(s_q) + NodeW'(1);
      depth_q <= '0;
      bits_q  <= '0;
    end else if (cmd_i.walk_st) begin
      // branches past the code width fall off the shift
      bits_q  <= bits_q | (CodeW'(pram_rdata[0]) << depth_q);
      depth_q <= depth_q + NW1'(1);
      cur_q   <= pram_rdata[NodeW:1];
    end
    if (emit_go) begin
      out_sym_q  <= SymIdxW'(s_q);
      out_len_q  <= LenW'(depth_q);
      out_bits_q <= bits_q;
      out_ovf_q  <= dropped_q;
      out_last_q <= sts_o.last_sym;
    end
  end

  assign s_axis_tready = cmd_i.load;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = OutDataW'({out_bits_q, out_len_q, out_sym_q});
  assign m_axis_tlast  = out_last_q;
  assign m_axis_tuser  = out_ovf_q;

  `HCB_ASSERT_NEXT(a_run_clears_live, finish, live_q == '0)
  `HCB_ASSERT_NOW(a_pair_distinct, cmd_i.merge, a_idx_q != best_idx_q)
  `HCB_ASSERT_NOW(a_emit_in_run, cmd_i.emit, CntW'(s_q) < count_q)
  `HCB_ASSERT_NOW(a_node_bound, cmd_i.merge, n_q < NW1'(NodeCount))

endmodule
`default_nettype wire

[src/huffman_code_builder.sv]
// top level of the huffman code builder
`timescale 1ns / 1ps
`default_nettype none
// huffman code builder: frequencies stream in one word per symbol, in symbol
// order, with tlast on the final one; up to MAX_SYMBOLS are kept and any
// further words are dropped and reported on the overflow flag of every result.
// after the last word the block builds the tree by repeated merges of the two
// live nodes with least (weight, tie index), ties going to the lower index,
// then sends one code word per symbol in index order, code read root first
// with the first branch at bit code_length-1; a lone symbol gets length zero.
// the input is ready throughout loading. each of the n-1 merges runs two
// linear scans over the m nodes made so far (one read per cycle, registered
// read) plus bookkeeping in the take, merge and parent states, with the prep
// state before the first merge. each code walks from its leaf to the root
// through the parent memory, one level per pass through the check, read and
// store states, then the emit state issues the result once the output
// register is free. no input is taken while the tree is built or the codes
// are sent; the output register lets the last result wait while the next
// run starts loading.
module huffman_code_builder #(
  parameter int unsigned MAX_SYMBOLS = 16,
  parameter int unsigned FREQ_WIDTH  = 16
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  // input stream
  input  wire logic                          s_axis_tvalid,
  output logic                               s_axis_tready,
  input  wire logic [hcb_pkg::InDataW-1:0]   s_axis_tdata,  // [15:0] frequency
  input  wire logic                          s_axis_tlast,  // last_symbol
  // code stream
  output logic                               m_axis_tvalid,
  input  wire logic                          m_axis_tready,
  output logic      [hcb_pkg::OutDataW-1:0]  m_axis_tdata,  // [3:0] symbol_index,
                                                            // [7:4] code_length,
                                                            // [22:8] code_bits
  output logic                               m_axis_tlast,  // final_code
  output logic                               m_axis_tuser   // overflow
);
  import hcb_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // state machine: load, merge rounds, code walk, emit
  hcb_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .sts_i  (sts),
    .cmd_o  (cmd)
  );

  // node memories, scan unit, walk and output register
  hcb_datapath #(
    .MAX_SYMBOLS (MAX_SYMBOLS),
    .FREQ_WIDTH  (FREQ_WIDTH)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
  );

endmodule
`default_nettype wire

[test/tb.sv]
// self-checking testbench for the huffman code builder
`timescale 1ns / 1ps
`default_nettype none
module tb;

  localparam int unsigned NSYM   = 16;
  localparam int unsigned NNODES = 2 * NSYM - 1;
  localparam int unsigned CYCLE_LIMIT = 2000000;

  // one frequency word as the sender sees it
  typedef struct packed {
    logic [15:0] freq;
    logic        last;
  } freq_word_t;

  // one code word as the receiver expects it
  typedef struct packed {
    logic [3:0]  sym;
    logic [3:0]  len;
    logic [14:0] bits;
    logic        ovf;
    logic        fin;
  } code_word_t;

  logic clk_i;
  logic rst_ni;
  logic s_axis_tvalid;
  logic s_axis_tready;
  logic [hcb_pkg::InDataW-1:0] s_axis_tdata;
  logic s_axis_tlast;
  logic m_axis_tvalid;
  logic m_axis_tready;
  logic [hcb_pkg::OutDataW-1:0] m_axis_tdata;
  logic m_axis_tlast;
  logic m_axis_tuser;

  huffman_code_builder u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
  );

  always begin
    clk_i = 1'b1;
    #4;
    clk_i = 1'b0;
    #4;
  end

  freq_word_t pending_words[$];
  code_word_t expected_codes[$];
  int unsigned mismatch_count;
  int unsigned cycle_count;
  bit src_noidle;
  bit snk_noidle;
  bit hold_src;

  // handshake seen at the rising edge, used by the driver on the next falling edge
  logic s_axis_tready_q;

  // predictor state for the tree being loaded
  logic [19:0] pr_weight[NNODES];
  logic [3:0]  pr_tie[NNODES];
  logic [4:0]  pr_parent[NNODES];
  logic        pr_branch[NNODES];
  logic        pr_live[NNODES];
  int unsigned pr_count;
  logic        pr_dropped;

  function automatic int unsigned least_node(int unsigned n);
    int unsigned best;
    bit found;
    best = 0;
    found = 0;
    for (int unsigned i = 0; i < n; i++) begin
      if (pr_live[i] && (!found || pr_weight[i] < pr_weight[best] ||
          (pr_weight[i] == pr_weight[best] && pr_tie[i] < pr_tie[best]))) begin
        best = i;
        found = 1;
      end
    end
    return best;
  endfunction

  // append a word to the sender's queue
  task automatic queue_word(input freq_word_t w);
    pending_words.insert(pending_words.size(), w);
  endtask

  // store the frequency; on the marked word build the tree and queue the codes
  task automatic predict_codes(input freq_word_t w);
    int unsigned n, a, b, cur, depth;
    logic [14:0] bits;
    code_word_t c;
    if (pr_count < NSYM) begin
      pr_weight[pr_count] = {4'd0, w.freq};
      pr_tie[pr_count]    = pr_count[3:0];
      pr_parent[pr_count] = '0;
      pr_branch[pr_count] = 1'b0;
      pr_live[pr_count]   = 1'b1;
      pr_count++;
    end else begin
      pr_dropped = 1'b1;
    end
    if (!w.last) return;
    n = pr_count;
    while (n - (n - pr_count) > 0 && (2 * pr_count - 1) > n) begin
      a = least_node(n);
      pr_live[a] = 1'b0;
      b = least_node(n);
      pr_live[b] = 1'b0;
      pr_weight[n] = pr_weight[a] + pr_weight[b];
      pr_tie[n] = pr_tie[a];
      pr_parent[n] = '0;
      pr_branch[n] = 1'b0;
      pr_live[n] = 1'b1;
      pr_parent[a] = n[4:0];
      pr_branch[a] = 1'b0;
      pr_parent[b] = n[4:0];
      pr_branch[b] = 1'b1;
      n++;
    end
    for (int unsigned s = 0; s < pr_count; s++) begin
      bits = '0;
      depth = 0;
      cur = s;
      if (pr_count > 1) begin
        while (cur + 1 < n) begin
          if (depth < 15 && pr_branch[cur]) bits[depth] = 1'b1;
          depth++;
          cur = 32'(pr_parent[cur]);
        end
      end
      c.sym  = s[3:0];
      c.len  = depth[3:0];
      c.bits = bits;
      c.ovf  = pr_dropped;
      c.fin  = (s + 1 == pr_count);
      expected_codes.insert(expected_codes.size(), c);
    end
    for (int unsigned i = 0; i < NNODES; i++) pr_live[i] = 1'b0;
    pr_count = 0;
    pr_dropped = 1'b0;
  endtask

  // driver: one word from the queue, gaps at random, and random sink stalls
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!s_axis_tvalid || s_axis_tready_q) begin
        if (s_axis_tvalid && s_axis_tready_q) void'(pending_words.pop_front());
        if (pending_words.size() > 0 && !hold_src &&
            (src_noidle || $urandom_range(99) >= 10)) begin
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= pending_words[0].freq;
          s_axis_tlast  <= pending_words[0].last;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
      m_axis_tready <= snk_noidle || ($urandom_range(99) >= 10);
    end
  end

  always @(posedge clk_i) begin
    s_axis_tready_q <= s_axis_tvalid && s_axis_tready;
    if (rst_ni && s_axis_tvalid && s_axis_tready) predict_codes(pending_words[0]);
  end

  // monitor: compare each code word with the oldest expectation
  always @(posedge clk_i) begin
    code_word_t got, exp_c;
    if (rst_ni) begin
      cycle_count <= cycle_count + 1;
      if (m_axis_tvalid && m_axis_tready) begin
        got.sym  = m_axis_tdata[3:0];
        got.len  = m_axis_tdata[7:4];
        got.bits = m_axis_tdata[22:8];
        got.ovf  = m_axis_tuser;
        got.fin  = m_axis_tlast;
        if (expected_codes.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10) $display("unexpected code word %h", got);
        end else begin
          exp_c = expected_codes.pop_front();
          if (got !== exp_c) begin
            mismatch_count++;
            if (mismatch_count <= 10) begin
              $display("code mismatch: expected sym %0d len %0d bits %h ovf %b last %b",
                       exp_c.sym, exp_c.len, exp_c.bits, exp_c.ovf, exp_c.fin);
              $display("               got      sym %0d len %0d bits %h ovf %b last %b",
                       got.sym, got.len, got.bits, got.ovf, got.fin);
            end
          end
        end
      end
      if (cycle_count > CYCLE_LIMIT) begin
        $display("Mismatches found");
        $finish;
      end
    end
  end

  // queue one run of n words with weights shaped by mode: random, small random, a power of two, or all ones
  task automatic add_run(input int unsigned n, input int unsigned mode);
    freq_word_t w;
    for (int unsigned i = 0; i < n; i++) begin
      case (mode)
        0: w.freq = 16'($urandom_range(65535));
        1: w.freq = 16'($urandom_range(7));
        2: w.freq = 16'd1 << $urandom_range(15);
        default: w.freq = 16'hffff;
      endcase
      w.last = (i + 1 == n);
      queue_word(w);
    end
  endtask

  initial begin
    int unsigned loaded;
    rst_ni = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tlast = 1'b0;
    m_axis_tready = 1'b0;
    mismatch_count = 0;
    cycle_count = 0;
    src_noidle = 0;
    snk_noidle = 0;
    hold_src = 0;
    pr_count = 0;
    pr_dropped = 1'b0;
    for (int unsigned i = 0; i < NNODES; i++) pr_live[i] = 1'b0;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed: lone symbol, zero weights, equal weights, full set, overflow
    queue_word(freq_word_t'{16'h0000, 1'b1});
    queue_word(freq_word_t'{16'hffff, 1'b1});
    queue_word(freq_word_t'{16'h0000, 1'b0});
    queue_word(freq_word_t'{16'h0000, 1'b1});
    add_run(4, 3);
    add_run(16, 3);
    add_run(18, 2);
    wait (pending_words.size() == 0 && expected_codes.size() == 0);

    // hold the sender while a new run is queued, then release it
    hold_src = 1;
    add_run(5, 1);
    repeat (20) @(posedge clk_i);
    hold_src = 0;

    loaded = 0;
    while (loaded < 420) begin
      int unsigned n, r;
      r = $urandom_range(99);
      n = (r < 10) ? $urandom_range(17, 20) : $urandom_range(1, 16);
      add_run(n, $urandom_range(2));
      loaded += n;
      if (loaded > 150 && loaded < 260) begin
        src_noidle = 1;
        snk_noidle = 1;
      end else begin
        src_noidle = 0;
        snk_noidle = 0;
      end
      wait (pending_words.size() < 8);
    end
    wait (pending_words.size() == 0 && expected_codes.size() == 0);
    repeat (50) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
`default_nettype wire

[files.f]
+incdir+src
src/hcb_pkg.sv
src/hcb_ram.sv
src/hcb_ctrl.sv
src/hcb_datapath.sv
src/huffman_code_builder.sv
test/tb.sv
